// File: design/token_bucket_rate_limiter_top_defines.svh
// assertion macros for the token bucket rate limiter
// used by token_bucket_rate_limiter_top, expects clk and rst_n in scope
`ifndef TOKEN_BUCKET_RATE_LIMITER_TOP_DEFINES_SVH
`define TOKEN_BUCKET_RATE_LIMITER_TOP_DEFINES_SVH

// checked only outside reset
`define TBRL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TBRL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/tbrl_pkg.sv
// types and constants for the token bucket rate limiter
// no dependencies
`default_nettype none

package tbrl_pkg;

  typedef enum logic [2:0] {
    REQ_TICK          = 3'd0,
    REQ_TRY_TAKE      = 3'd1,
    REQ_ACQUIRE       = 3'd2,
    REQ_TIMED_ACQUIRE = 3'd3,
    REQ_RESET         = 3'd4,
    REQ_QUERY         = 3'd5
  } req_type_t;

  typedef enum logic [2:0] {
    STAT_GRANTED   = 3'd0,
    STAT_REFUSED   = 3'd1,
    STAT_TIMED_OUT = 3'd2,
    STAT_BUSY      = 3'd3,
    STAT_REPORT    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_REFILL_INTERVAL = 3'd0,
    CFG_MAX_TOKENS      = 3'd1,
    CFG_INITIAL_TOKENS  = 3'd2,
    CFG_WAIT_LIMIT_EN   = 3'd3,
    CFG_WAIT_LIMIT_MS   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] wait_ms;
  } tbrl_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] tokens_left;
  } tbrl_out_t;

  localparam logic [15:0] RST_REFILL_INTERVAL = 16'd1000;
  localparam logic [15:0] RST_MAX_TOKENS      = 16'd10;
  localparam logic [15:0] RST_INITIAL_TOKENS  = 16'd10;
  localparam logic        RST_WAIT_LIMIT_EN   = 1'b0;
  localparam logic [31:0] RST_WAIT_LIMIT_MS   = 32'd0;

endpackage

`default_nettype wire

// File: design/token_bucket_rate_limiter_top.sv
// a request waits in the input register, then its result goes to the output register
// throughput: one request or tick per cycle, output register stalls only on out_ready low
// requests causing no result (plain ticks, failed retries, unused codes) leave no output
// reset: synchronous active low, restores control registers, full bucket of initial tokens
// depends on tbrl_pkg and token_bucket_rate_limiter_top_defines.svh
`default_nettype none

`include "token_bucket_rate_limiter_top_defines.svh"

module token_bucket_rate_limiter_top
  import tbrl_pkg::*;
#(
  parameter int TOKEN_BITS = 16,
  parameter int WAIT_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire tbrl_in_t    in_data,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      tbrl_out_t   out_data,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wr_data
);

  localparam int TW = (TOKEN_BITS > 16) ? TOKEN_BITS : 16;
  localparam int SW = TW + 1;
  localparam logic [63:0] WAIT_MAX = {64{1'b1}} >> (64 - WAIT_BITS);

  // configuration
  logic [15:0] cfg_interval_r;
  logic [15:0] cfg_max_r;
  logic [15:0] cfg_init_r;
  logic        cfg_wait_en_r;
  logic [31:0] cfg_wait_ms_r;

  // state
  logic [TOKEN_BITS-1:0] token_count_r, token_count_nxt;
  logic [15:0]           partial_ms_r, partial_ms_nxt;
  logic [15:0]           whole_intervals_r, whole_intervals_nxt;
  logic                  wait_pending_r, wait_pending_nxt;
  logic                  wait_bounded_r, wait_bounded_nxt;
  logic [WAIT_BITS-1:0]  wait_remaining_r, wait_remaining_nxt;

  // input register and output register
  logic        s1_valid_r;
  tbrl_in_t    s1_req_r;
  logic        out_valid_r;
  tbrl_out_t   out_data_r;

  logic        s1_adv;
  logic        s1_fire;
  logic        emit;
  status_t     emit_status;
  logic [15:0] tokens_ext;

  logic [TW-1:0]         max_ext;
  logic [TW-1:0]         init_ext;
  logic [TW-1:0]         tok_ext;
  logic [TOKEN_BITS-1:0] cap;
  logic [TOKEN_BITS-1:0] init_tok;

  function automatic logic [TOKEN_BITS-1:0] refill_tok(
    input logic [TOKEN_BITS-1:0] tok,
    input logic [15:0]           whole,
    input logic [TOKEN_BITS-1:0] ceil
  );
    logic [SW-1:0] sum;
    sum = SW'(tok) + SW'(whole);
    refill_tok = (sum < SW'(ceil)) ? sum[TOKEN_BITS-1:0] : ceil;
  endfunction

  function automatic logic [WAIT_BITS-1:0] clip_wait(input logic [31:0] w);
    logic [63:0] w64;
    w64 = 64'(w);
    clip_wait = (w64 > WAIT_MAX) ? WAIT_MAX[WAIT_BITS-1:0] : w64[WAIT_BITS-1:0];
  endfunction

  assign max_ext  = TW'(cfg_max_r);
  assign init_ext = TW'(cfg_init_r);
  assign cap      = max_ext[TOKEN_BITS-1:0];
  assign init_tok = init_ext[TOKEN_BITS-1:0];

  assign s1_adv    = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // request processing
  always_comb begin
    logic [15:0]          lim;
    logic [15:0]          part_inc;
    logic                 bounded;
    logic [31:0]          wsel;
    logic                 timeout;
    token_count_nxt     = token_count_r;
    partial_ms_nxt      = partial_ms_r;
    whole_intervals_nxt = whole_intervals_r;
    wait_pending_nxt    = wait_pending_r;
    wait_bounded_nxt    = wait_bounded_r;
    wait_remaining_nxt  = wait_remaining_r;
    emit        = 1'b0;
    emit_status = STAT_REPORT;
    lim         = (cfg_interval_r == 16'd0) ? 16'd1 : cfg_interval_r;
    part_inc    = partial_ms_r + 16'd1;
    bounded     = 1'b0;
    wsel        = '0;
    timeout     = 1'b0;
    if (s1_fire) begin
      if (s1_req_r.req_type == REQ_TICK) begin
        if (part_inc >= lim) begin
          partial_ms_nxt = '0;
          if (whole_intervals_r != 16'hFFFF) begin
            whole_intervals_nxt = whole_intervals_r + 16'd1;
          end
        end else begin
          partial_ms_nxt = part_inc;
        end
        if (wait_pending_r) begin
          if (wait_bounded_r) begin
            wait_remaining_nxt = wait_remaining_r - WAIT_BITS'(1);
            if (wait_remaining_nxt == '0) begin
              timeout = 1'b1;
            end
          end
          if (timeout) begin
            wait_pending_nxt = 1'b0;
            wait_bounded_nxt = 1'b0;
            emit             = 1'b1;
            emit_status      = STAT_TIMED_OUT;
          end else begin
            if (whole_intervals_nxt != 16'd0) begin
              token_count_nxt     = refill_tok(token_count_r, whole_intervals_nxt, cap);
              whole_intervals_nxt = '0;
              partial_ms_nxt      = '0;
            end
            if (token_count_nxt != '0) begin
              token_count_nxt    = token_count_nxt - TOKEN_BITS'(1);
              wait_pending_nxt   = 1'b0;
              wait_bounded_nxt   = 1'b0;
              wait_remaining_nxt = '0;
              emit               = 1'b1;
              emit_status        = STAT_GRANTED;
            end
          end
        end
      end else if (s1_req_r.req_type <= REQ_QUERY) begin
        emit = 1'b1;
        if (wait_pending_r) begin
          emit_status = STAT_BUSY;
        end else begin
          unique case (s1_req_r.req_type)
            REQ_RESET: begin
              token_count_nxt     = init_tok;
              partial_ms_nxt      = '0;
              whole_intervals_nxt = '0;
              emit_status         = STAT_REPORT;
            end
            REQ_QUERY: begin
              emit_status = STAT_REPORT;
            end
            default: begin
              // try, plain acquire and timed acquire
              bounded = (s1_req_r.req_type == REQ_TIMED_ACQUIRE) ||
                        ((s1_req_r.req_type == REQ_ACQUIRE) && cfg_wait_en_r);
              wsel    = (s1_req_r.req_type == REQ_TIMED_ACQUIRE) ? s1_req_r.wait_ms
                                                                  : cfg_wait_ms_r;
              if (bounded && (wsel == 32'd0)) begin
                emit_status = STAT_TIMED_OUT;
              end else begin
                if (whole_intervals_r != 16'd0) begin
                  token_count_nxt     = refill_tok(token_count_r, whole_intervals_r, cap);
                  whole_intervals_nxt = '0;
                  partial_ms_nxt      = '0;
                end
                if (token_count_nxt != '0) begin
                  token_count_nxt = token_count_nxt - TOKEN_BITS'(1);
                  emit_status     = STAT_GRANTED;
                end else if (s1_req_r.req_type == REQ_TRY_TAKE) begin
                  emit_status = STAT_REFUSED;
                end else begin
                  emit               = 1'b0;
                  wait_pending_nxt   = 1'b1;
                  wait_bounded_nxt   = bounded;
                  wait_remaining_nxt = bounded ? clip_wait(wsel) : '0;
                end
              end
            end
          endcase
        end
      end
    end
  end

  assign tok_ext    = TW'(token_count_nxt);
  assign tokens_ext = tok_ext[15:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_interval_r <= RST_REFILL_INTERVAL;
      cfg_max_r      <= RST_MAX_TOKENS;
      cfg_init_r     <= RST_INITIAL_TOKENS;
      cfg_wait_en_r  <= RST_WAIT_LIMIT_EN;
      cfg_wait_ms_r  <= RST_WAIT_LIMIT_MS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_REFILL_INTERVAL: cfg_interval_r <= cfg_wr_data[15:0];
        CFG_MAX_TOKENS:      cfg_max_r      <= cfg_wr_data[15:0];
        CFG_INITIAL_TOKENS:  cfg_init_r     <= cfg_wr_data[15:0];
        CFG_WAIT_LIMIT_EN:   cfg_wait_en_r  <= cfg_wr_data[0];
        CFG_WAIT_LIMIT_MS:   cfg_wait_ms_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // limiter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_count_r     <= TOKEN_BITS'(RST_INITIAL_TOKENS);
      partial_ms_r      <= '0;
      whole_intervals_r <= '0;
      wait_pending_r    <= 1'b0;
      wait_bounded_r    <= 1'b0;
      wait_remaining_r  <= '0;
    end else begin
      token_count_r     <= token_count_nxt;
      partial_ms_r      <= partial_ms_nxt;
      whole_intervals_r <= whole_intervals_nxt;
      wait_pending_r    <= wait_pending_nxt;
      wait_bounded_r    <= wait_bounded_nxt;
      wait_remaining_r  <= wait_remaining_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r <= in_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_data_r.status      <= emit_status;
      out_data_r.tokens_left <= tokens_ext;
    end
  end

  `TBRL_ASSERT(a_bounded_wait_nonzero,
    (wait_pending_r && wait_bounded_r |-> wait_remaining_r != '0),
    "bounded wait pending with zero time left")
  `TBRL_ASSERT(a_bounded_needs_pending,
    (!wait_pending_r |-> !wait_bounded_r),
    "bounded flag set without a pending acquire")
  `TBRL_ASSERT(a_stall_holds_request,
    (s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_req_r)),
    "stalled request lost or changed")
  `TBRL_ASSERT(a_ready_low_only_on_stall,
    (!in_ready |-> out_valid_r && !out_ready && s1_valid_r),
    "input stalled without output backpressure")
  `TBRL_ASSERT_ALWAYS(a_reset_clears_output,
    (!rst_n |=> !out_valid_r && !wait_pending_r),
    "reset left a result or pending acquire")

endmodule

`default_nettype wire

// File: dv/token_bucket_rate_limiter_checker.sv
`timescale 1ns / 100ps
// checker for the token bucket rate limiter: watches the config port and both channels,
// keeps its own bucket state, predicts each result and compares it with the block output
// depends on tbrl_pkg
module token_bucket_rate_limiter_checker
  import tbrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  tbrl_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  tbrl_out_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wr_data,
  output int          err_count,
  output int          outstanding,
  output logic        acq_waiting,
  output int          results_seen
);

  logic [15:0] interval_ms;
  logic [15:0] max_tok;
  logic [15:0] init_tok;
  logic        wait_en;
  logic [31:0] wait_lim;

  logic [15:0] tokens;
  logic [15:0] part_ms;
  logic [15:0] intervals;
  logic        acq_pend;
  logic        acq_bounded;
  logic [31:0] wait_left;

  tbrl_out_t expected_results[$];
  int        errs = 0;
  int        seen = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errs++;
  endtask

  function automatic void refill();
    logic [16:0] sum;
    if (intervals != 16'd0) begin
      sum = tokens + intervals;
      tokens = (sum < {1'b0, max_tok}) ? sum[15:0] : max_tok;
      intervals = '0;
      part_ms = '0;
    end
  endfunction

  function automatic bit take_token();
    refill();
    if (tokens != 16'd0) begin
      tokens = tokens - 16'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void advance_ms();
    logic [15:0] lim;
    lim = (interval_ms == 16'd0) ? 16'd1 : interval_ms;
    part_ms = part_ms + 16'd1;
    if (part_ms >= lim) begin
      part_ms = '0;
      if (intervals != 16'hFFFF) intervals = intervals + 16'd1;
    end
  endfunction

  function automatic void push_result(status_t st);
    tbrl_out_t e;
    e.status      = st;
    e.tokens_left = tokens;
    expected_results.push_back(e);
  endfunction

  function automatic void start_acquire(bit bnd, logic [31:0] w);
    if (bnd && w == 32'd0) begin
      push_result(STAT_TIMED_OUT);
    end else if (take_token()) begin
      push_result(STAT_GRANTED);
    end else begin
      acq_pend    = 1'b1;
      acq_bounded = bnd;
      wait_left   = bnd ? w : 32'd0;
    end
  endfunction

  function automatic void predict_bucket(tbrl_in_t r);
    if (r.req_type == REQ_TICK) begin
      advance_ms();
      if (!acq_pend) return;
      if (acq_bounded) begin
        wait_left = wait_left - 32'd1;
        if (wait_left == 32'd0) begin
          acq_pend    = 1'b0;
          acq_bounded = 1'b0;
          push_result(STAT_TIMED_OUT);
          return;
        end
      end
      if (take_token()) begin
        acq_pend    = 1'b0;
        acq_bounded = 1'b0;
        wait_left   = '0;
        push_result(STAT_GRANTED);
      end
    end else if (r.req_type > REQ_QUERY) begin
      return;
    end else if (acq_pend) begin
      push_result(STAT_BUSY);
    end else begin
      case (r.req_type)
        REQ_TRY_TAKE:      push_result(take_token() ? STAT_GRANTED : STAT_REFUSED);
        REQ_ACQUIRE:       start_acquire(wait_en, wait_lim);
        REQ_TIMED_ACQUIRE: start_acquire(1'b1, r.wait_ms);
        REQ_RESET: begin
          tokens    = init_tok;
          part_ms   = '0;
          intervals = '0;
          push_result(STAT_REPORT);
        end
        default: push_result(STAT_REPORT);
      endcase
    end
  endfunction

  always @(posedge clk) begin
    tbrl_out_t e;
    if (!rst_n) begin
      interval_ms = RST_REFILL_INTERVAL;
      max_tok     = RST_MAX_TOKENS;
      init_tok    = RST_INITIAL_TOKENS;
      wait_en     = RST_WAIT_LIMIT_EN;
      wait_lim    = RST_WAIT_LIMIT_MS;
      tokens      = RST_INITIAL_TOKENS;
      part_ms     = '0;
      intervals   = '0;
      acq_pend    = 1'b0;
      acq_bounded = 1'b0;
      wait_left   = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result status %0d tokens %0d with nothing expected",
                                    out_data.status, out_data.tokens_left));
        end else begin
          e = expected_results.pop_front();
          if (out_data.status !== e.status)
            report_mismatch($sformatf("status expected %0d got %0d", e.status,
                                      out_data.status));
          if (out_data.tokens_left !== e.tokens_left)
            report_mismatch($sformatf("tokens_left expected %0d got %0d", e.tokens_left,
                                      out_data.tokens_left));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_REFILL_INTERVAL: interval_ms = cfg_wr_data[15:0];
          CFG_MAX_TOKENS:      max_tok     = cfg_wr_data[15:0];
          CFG_INITIAL_TOKENS:  init_tok    = cfg_wr_data[15:0];
          CFG_WAIT_LIMIT_EN:   wait_en     = cfg_wr_data[0];
          CFG_WAIT_LIMIT_MS:   wait_lim    = cfg_wr_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_bucket(in_data);
    end
    err_count    <= errs;
    outstanding  <= expected_results.size();
    acq_waiting  <= acq_pend;
    results_seen <= seen;
  end

endmodule

// File: dv/token_bucket_rate_limiter_top_tb.sv
`timescale 1ns / 100ps
// top of the token bucket rate limiter testbench: clock, reset, config writes and requests
// depends on tbrl_pkg, token_bucket_rate_limiter_top and token_bucket_rate_limiter_checker
module token_bucket_rate_limiter_top_tb;
  import tbrl_pkg::*;

  localparam int LIMIT           = 1_000_000;
  localparam int ITEMS_PER_PHASE = 175;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  tbrl_in_t    in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  tbrl_out_t   out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [2:0]  cfg_index   = '0;
  logic [31:0] cfg_wr_data = '0;

  int   err_count;
  int   outstanding;
  logic acq_waiting;
  int   results_seen;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int n_sent        = 0;
  int n_phases      = 0;
  int cycles        = 0;

  token_bucket_rate_limiter_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  token_bucket_rate_limiter_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .err_count    (err_count),
    .outstanding  (outstanding),
    .acq_waiting  (acq_waiting),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped at the cycle limit of %0d", LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 66; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 66; end
      default: begin send_idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  function automatic tbrl_in_t make_request(input logic [2:0] kind, input logic [31:0] w);
    tbrl_in_t r;
    r.req_type = kind;
    r.wait_ms  = w;
    return r;
  endfunction

  function automatic tbrl_in_t rand_request(input bit long_ok);
    tbrl_in_t r;
    int       pick;
    pick      = $urandom_range(0, 99);
    r.wait_ms = $urandom();
    if (pick < 45) begin
      r.req_type = REQ_TICK;
    end else if (pick < 58) begin
      r.req_type = REQ_TRY_TAKE;
    end else if (pick < 68) begin
      r.req_type = REQ_ACQUIRE;
    end else if (pick < 80) begin
      r.req_type = REQ_TIMED_ACQUIRE;
      case ($urandom_range(0, 3))
        0: r.wait_ms = '0;
        1: r.wait_ms = $urandom_range(1, 4);
        2: r.wait_ms = $urandom_range(5, 40);
        default: if (!long_ok) r.wait_ms = $urandom_range(1, 40);
      endcase
    end else if (pick < 86) begin
      r.req_type = REQ_RESET;
    end else if (pick < 94) begin
      r.req_type = REQ_QUERY;
    end else begin
      r.req_type = 3'($urandom_range(6, 7));
    end
    return r;
  endfunction

  task automatic issue_request(input tbrl_in_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic cfg_write(input cfg_index_t idx, input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [15:0] ivl, input logic [15:0] mx,
                              input logic [15:0] ini, input logic wen,
                              input logic [31:0] wl);
    cfg_write(CFG_REFILL_INTERVAL, {16'd0, ivl});
    cfg_write(CFG_MAX_TOKENS, {16'd0, mx});
    cfg_write(CFG_INITIAL_TOKENS, {16'd0, ini});
    cfg_write(CFG_WAIT_LIMIT_EN, {31'd0, wen});
    cfg_write(CFG_WAIT_LIMIT_MS, wl);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 4000 && outstanding != 0; k++) @(posedge clk);
  endtask

  // ticks until any pending acquire has resolved, then let the pipeline empty
  task automatic quiesce();
    wait_drained();
    while (acq_waiting) begin
      issue_request(make_request(REQ_TICK, $urandom()));
      wait_drained();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] ivl, input logic [15:0] mx,
                           input logic [15:0] ini, input logic wen,
                           input logic [31:0] wl, input bit long_ok, input int mode);
    set_idle(mode);
    apply_config(ivl, mx, ini, wen, wl);
    issue_request(make_request(REQ_RESET, $urandom()));
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (i == ITEMS_PER_PHASE / 2 || $urandom_range(0, 149) == 0) wait_drained();
      issue_request(rand_request(long_ok));
    end
    quiesce();
    n_phases++;
  endtask

  initial begin
    set_idle(0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of the registers and the bucket
    issue_request(make_request(REQ_QUERY, 32'h0));
    issue_request(make_request(REQ_TRY_TAKE, 32'hFFFF_FFFF));
    issue_request(make_request(REQ_ACQUIRE, 32'h0));
    issue_request(make_request(REQ_TIMED_ACQUIRE, 32'h0));
    issue_request(make_request(REQ_TIMED_ACQUIRE, 32'hFFFF_FFFF));
    issue_request(make_request(REQ_RESET, 32'h0));
    issue_request(make_request(3'd6, 32'hFFFF_FFFF));
    issue_request(make_request(3'd7, 32'h0));
    issue_request(make_request(REQ_TICK, 32'hFFFF_FFFF));
    quiesce();

    // empty bucket: pending acquire, busy replies, grant on refill, timeout
    apply_config(16'd2, 16'd1, 16'd0, 1'b1, 32'd3);
    issue_request(make_request(REQ_RESET, 32'h0));
    issue_request(make_request(REQ_TRY_TAKE, 32'h0));
    issue_request(make_request(REQ_ACQUIRE, 32'h0));
    issue_request(make_request(REQ_QUERY, 32'h0));
    issue_request(make_request(REQ_TRY_TAKE, 32'h0));
    issue_request(make_request(REQ_TIMED_ACQUIRE, 32'd5));
    issue_request(make_request(REQ_RESET, 32'h0));
    issue_request(make_request(REQ_TICK, 32'h0));
    issue_request(make_request(REQ_TICK, 32'h0));
    issue_request(make_request(REQ_TIMED_ACQUIRE, 32'd1));
    issue_request(make_request(REQ_TICK, 32'h0));
    issue_request(make_request(REQ_ACQUIRE, 32'h0));
    issue_request(make_request(REQ_TICK, 32'h0));
    quiesce();

    // many whole intervals build up before a single refill
    apply_config(16'd1, 16'hFFFF, 16'd0, 1'b0, 32'd0);
    issue_request(make_request(REQ_RESET, 32'h0));
    repeat (40) issue_request(make_request(REQ_TICK, 32'h0));
    issue_request(make_request(REQ_QUERY, 32'h0));
    issue_request(make_request(REQ_TRY_TAKE, 32'h0));
    quiesce();

    run_phase(16'd4,     16'd6,     16'd3,     1'b0, 32'd0,          1, 0);
    run_phase(16'd1,     16'd1,     16'd0,     1'b1, 32'hFFFF_FFFF,  1, 1);
    run_phase(16'd0,     16'hFFFF,  16'hFFFF,  1'b1, 32'd0,          1, 2);
    run_phase(16'hFFFF,  16'd0,     16'd0,     1'b1, 32'd7,          0, 3);
    run_phase(16'd3,     16'd2,     16'd9,     1'b0, 32'd0,          1, 0);
    run_phase(16'd16,    16'hFFFF,  16'd0,     1'b1, 32'd20,         0, 1);
    run_phase(16'd7,     16'd2,     16'd1,     1'b0, 32'hA5A5_5A5A,  1, 2);
    run_phase(16'hFFFF,  16'hFFFF,  16'd4,     1'b1, 32'd3,          0, 3);
    run_phase(16'd2,     16'd1,     16'hFFFF,  1'b1, 32'd1,          1, 0);

    $display("sent %0d requests across %0d random config phases plus directed cases",
             n_sent, n_phases);
    $display("checked %0d results, %0d mismatches", results_seen, err_count);
    if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
    if (err_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
